>>> sv/swlm_pkg.sv
package swlm_pkg;

  localparam int unsigned DefWindowDepth = 64;
  localparam int unsigned IdW   = 64;
  localparam int unsigned TimeW = 48;
  localparam int unsigned LatW  = 31;
  localparam logic [LatW-1:0] LatMax = 31'd2147483646;

  localparam logic OpStart  = 1'b0;
  localparam logic OpFinish = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [IdW-1:0]   request_id;
    logic [TimeW-1:0] time_us;
  } in_item_t;

  typedef struct packed {
    logic [31:0] median_twice;
    logic        has_median;
    logic [6:0]  window_entries;
    logic [6:0]  completed_entries;
    logic        id_mismatch;
  } out_item_t;

endpackage

>>> sv/swlm_ram.sv
module swlm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> sv/sliding_window_latency_median_top.sv
// Each transaction runs from accept to result through the state machine; a sorted-list insert or delete
// walks the list entry by entry, with a read state and a check state for each entry, and a repeated finish does both.
// One transaction at a time: a new item is accepted only in the idle state. The result register frees the
// input side once it is loaded, so the next item is taken while a result waits.
// Reset: asynchronous, active low; clears counters, done bits and the state machine.
// No clearing pass: record and sorted RAMs are read only at written entries.
module sliding_window_latency_median_top #(
  parameter int unsigned WINDOW_DEPTH = swlm_pkg::DefWindowDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  swlm_pkg::in_item_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output swlm_pkg::out_item_t out_data_o
);
  import swlm_pkg::*;

  localparam int unsigned AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(WINDOW_DEPTH);
  localparam int unsigned SW = LatW + AW;

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StRecRd  = 4'd1;
  localparam logic [3:0] StRecChk = 4'd2;
  localparam logic [3:0] StRmRd   = 4'd3;
  localparam logic [3:0] StRmChk  = 4'd4;
  localparam logic [3:0] StInsRd  = 4'd5;
  localparam logic [3:0] StInsChk = 4'd6;
  localparam logic [3:0] StMedRd  = 4'd7;
  localparam logic [3:0] StMedA   = 4'd8;
  localparam logic [3:0] StMedB   = 4'd9;
  localparam logic [3:0] StOut    = 4'd10;

  logic [3:0] state_q, state_d;
  in_item_t item_q;
  logic [AW-1:0] oldest_q, oldest_d;
  logic [CW-1:0] count_q, count_d, done_q, done_d;
  logic [WINDOW_DEPTH-1:0] rdone_q, rdone_d;
  logic mism_q, mism_d;
  logic [AW-1:0] slot_q, slot_d;
  logic [CW-1:0] idx_q, idx_d;
  logic shifting_q, shifting_d;
  logic [SW-1:0] carry_q, carry_d;
  logic [LatW-1:0] lat_q, lat_d;
  logic ins_q, ins_d;
  logic [31:0] med_q, med_d;
  logic ovalid_q, ovalid_d;
  out_item_t odata_q, odata_d;

  // record RAM: id, start time
  logic rec_we;
  logic [AW-1:0] rec_waddr, rec_raddr;
  logic [IdW+TimeW-1:0] rec_wdata, rec_rdata;
  // sorted RAM: latency, slot tag
  logic srt_we;
  logic [AW-1:0] srt_waddr, srt_raddr;
  logic [SW-1:0] srt_wdata, srt_rdata;

  swlm_ram #(.Width(IdW + TimeW), .Depth(WINDOW_DEPTH)) u_rec_ram (
    .clk_i, .we_i(rec_we), .waddr_i(rec_waddr), .wdata_i(rec_wdata),
    .raddr_i(rec_raddr), .rdata_o(rec_rdata)
  );
  swlm_ram #(.Width(SW), .Depth(WINDOW_DEPTH)) u_srt_ram (
    .clk_i, .we_i(srt_we), .waddr_i(srt_waddr), .wdata_i(srt_wdata),
    .raddr_i(srt_raddr), .rdata_o(srt_rdata)
  );

  logic [TimeW-1:0] diff;
  logic [LatW-1:0] srt_lat;
  logic [AW-1:0] srt_tag;
  assign srt_lat = srt_rdata[SW-1:AW];
  assign srt_tag = srt_rdata[AW-1:0];

  function automatic logic [AW-1:0] wrap(input logic [CW:0] v);
    logic [CW:0] r;
    r = (v >= (CW+1)'(WINDOW_DEPTH)) ? v - (CW+1)'(WINDOW_DEPTH) : v;
    return r[AW-1:0];
  endfunction

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;
  assign diff = item_q.time_us - rec_rdata[TimeW-1:0];

  always_comb begin
    state_d = state_q; oldest_d = oldest_q; count_d = count_q; done_d = done_q;
    rdone_d = rdone_q; mism_d = mism_q; slot_d = slot_q; idx_d = idx_q;
    shifting_d = shifting_q; carry_d = carry_q; lat_d = lat_q; ins_d = ins_q;
    med_d = med_q; ovalid_d = ovalid_q; odata_d = odata_q;
    rec_we = 1'b0; rec_waddr = slot_q;
    rec_wdata = {item_q.request_id, item_q.time_us}; rec_raddr = slot_q;
    srt_we = 1'b0; srt_waddr = idx_q[AW-1:0]; srt_wdata = carry_q;
    srt_raddr = idx_q[AW-1:0];
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          mism_d = 1'b0;
          ins_d = 1'b0;
          if (in_data_i.operation == OpStart) begin
            if (count_q == DepthC) begin
              slot_d = oldest_q;
              state_d = rdone_q[oldest_q] ? StRmRd : StRecRd;
            end else begin
              slot_d = wrap({1'b0, CW'(oldest_q)} + {1'b0, count_q});
              state_d = StRecRd;
            end
            idx_d = '0; shifting_d = 1'b0;
          end else if (count_q == '0) begin
            mism_d = 1'b1;
            state_d = StMedRd;
          end else begin
            slot_d = wrap({1'b0, CW'(oldest_q)} + {1'b0, count_q - CW'(1)});
            state_d = StRecRd;
          end
        end
      end
      StRecRd: begin
        if (item_q.operation == OpStart) begin
          // evicted record already handled; append new one
          if (count_q == DepthC) begin
            rdone_d[oldest_q] = 1'b0;
            oldest_d = wrap({1'b0, CW'(oldest_q)} + (CW+1)'(1));
            slot_d = oldest_q;
          end else begin
            count_d = count_q + CW'(1);
          end
          rec_we = 1'b1;
          rdone_d[slot_d] = 1'b0;
          state_d = StMedRd;
        end else begin
          state_d = StRecChk;
        end
      end
      StRecChk: begin
        if (rec_rdata[IdW+TimeW-1:TimeW] != item_q.request_id) begin
          mism_d = 1'b1;
          state_d = StMedRd;
        end else begin
          if (item_q.time_us <= rec_rdata[TimeW-1:0]) lat_d = '0;
          else if (diff > TimeW'(LatMax)) lat_d = LatMax;
          else lat_d = diff[LatW-1:0];
          ins_d = 1'b1;
          idx_d = '0; shifting_d = 1'b0;
          state_d = rdone_q[slot_q] ? StRmRd : StInsRd;
        end
      end
      StRmRd: begin
        if (idx_q >= done_q) begin
          state_d = StRecRd;  // not found, cannot happen
        end else begin
          state_d = StRmChk;
        end
      end
      StRmChk: begin
        // shift later entries down by one past the removed tag
        if (shifting_q) begin
          srt_we = 1'b1;
          srt_waddr = AW'(idx_q - CW'(1));
          srt_wdata = srt_rdata;
        end
        if (srt_tag == slot_q || shifting_q) shifting_d = 1'b1;
        idx_d = idx_q + CW'(1);
        if (idx_q + CW'(1) >= done_q) begin
          done_d = done_q - CW'(1);
          idx_d = '0;
          shifting_d = 1'b0;
          if (ins_q) begin
            carry_d = {lat_q, slot_q};
            state_d = StInsRd;
          end else begin
            count_d = DepthC;
            state_d = StRecRd;
          end
        end else begin
          state_d = StRmRd;
        end
      end
      StInsRd: begin
        if (!shifting_q) carry_d = {lat_q, slot_q};
        if (idx_q >= done_q) begin
          srt_we = 1'b1;
          srt_waddr = idx_q[AW-1:0];
          srt_wdata = shifting_q ? carry_q : {lat_q, slot_q};
          done_d = done_q + CW'(1);
          rdone_d[slot_q] = 1'b1;
          state_d = StMedRd;
        end else begin
          state_d = StInsChk;
        end
      end
      StInsChk: begin
        // once past the insert point, write carry and carry the old entry upward
        if (shifting_q || srt_lat > lat_q) begin
          srt_we = 1'b1;
          srt_wdata = shifting_q ? carry_q : {lat_q, slot_q};
          carry_d = srt_rdata;
          shifting_d = 1'b1;
        end
        idx_d = idx_q + CW'(1);
        state_d = StInsRd;
      end
      StMedRd: begin
        med_d = '0;
        if (done_q == '0) begin
          state_d = StOut;
        end else begin
          srt_raddr = AW'(done_q >> 1);
          state_d = StMedA;
        end
      end
      StMedA: begin
        if (done_q[0]) begin
          med_d = {srt_rdata[SW-1:AW], 1'b0};
          state_d = StOut;
        end else begin
          med_d = 32'(srt_lat);
          srt_raddr = AW'((done_q >> 1) - CW'(1));
          state_d = StMedB;
        end
      end
      StMedB: begin
        med_d = med_q + 32'(srt_lat);
        state_d = StOut;
      end
      StOut: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          odata_d.median_twice = med_q;
          odata_d.has_median = (done_q != '0);
          odata_d.window_entries = 7'(count_q);
          odata_d.completed_entries = 7'(done_q);
          odata_d.id_mismatch = mism_q;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      oldest_q <= '0;
      count_q <= '0;
      done_q <= '0;
      rdone_q <= '0;
      ovalid_q <= 1'b0;
      shifting_q <= 1'b0;
    end else begin
      state_q <= state_d;
      oldest_q <= oldest_d;
      count_q <= count_d;
      done_q <= done_d;
      rdone_q <= rdone_d;
      ovalid_q <= ovalid_d;
      shifting_q <= shifting_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) item_q <= in_data_i;
    mism_q <= mism_d;
    slot_q <= slot_d;
    idx_q <= idx_d;
    carry_q <= carry_d;
    lat_q <= lat_d;
    ins_q <= ins_d;
    med_q <= med_d;
    odata_q <= odata_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= DepthC)
    else $error("window count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q <= count_q)
    else $error("more completed than held");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q == $countones(rdone_q)) || (state_q != StIdle))
    else $error("done count disagrees with done bits");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut && state_d == StIdle) |=> out_valid_o)
    else $error("result lost");
endmodule
